[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("%m: assertion failed");

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("%m: assertion failed");

`endif

[hdl/qlu_pkg.sv]
// ---------------------------------------------------------------------------
// qlu_pkg
// shared types and constants of the q-learning update engine
// ---------------------------------------------------------------------------
`default_nettype none

package qlu_pkg;

  localparam int Q_W      = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic [CFG_W-1:0]        cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [1:0]              req_t;

  localparam req_t REQ_UPDATE = 2'd0;
  localparam req_t REQ_READ   = 2'd1;
  localparam req_t REQ_GREEDY = 2'd2;

  localparam cfg_idx_t CFG_LRATE = 1'd0;
  localparam cfg_idx_t CFG_DISC  = 1'd1;

  localparam cfg_word_t LRATE_RST = 16'd6554;
  localparam cfg_word_t DISC_RST  = 16'd64881;

  // stage strobes of the update arithmetic
  typedef struct packed {
    logic mul1;
    logic err;
    logic mul2;
  } upd_ctl_t;

endpackage

`default_nettype wire

[hdl/tabular_q_learning_update.sv]
// Update: the single table read port scans the next state one action a cycle, then the old
// entry is read, the update arithmetic runs and the result is written back to the table.
// Read: the addressed entry is read out. Greedy: the state's actions are scanned for the best one.
// One request is in flight at a time; a finished result waits in the output register.
// After reset the table is cleared one entry a cycle, all GRID_ROWS*GRID_COLS*NUM_ACTIONS
// entries (1280 by default), with in_ready low; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// tabular_q_learning_update
// q-learning value table with update, read and greedy action requests
// ---------------------------------------------------------------------------
`default_nettype none

module tabular_q_learning_update #(
  parameter int GRID_ROWS   = 16,
  parameter int GRID_COLS   = 16,
  parameter int NUM_ACTIONS = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qlu_pkg::req_t       in_req_type,
  input  wire logic [3:0]          in_state_row,
  input  wire logic [3:0]          in_state_col,
  input  wire logic [2:0]          in_action_index,
  input  wire logic [3:0]          in_next_row,
  input  wire logic [3:0]          in_next_col,
  input  wire qlu_pkg::q_t         in_reward_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qlu_pkg::q_t              out_q_value,
  output logic [2:0]               out_best_action,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire qlu_pkg::cfg_idx_t   cfg_index,
  input  wire qlu_pkg::cfg_word_t  cfg_data
);
  import qlu_pkg::*;

  localparam int DEPTH  = GRID_ROWS * GRID_COLS * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AX_W   = ADDR_W + 4;
  localparam int CNT_W  = $clog2(NUM_ACTIONS);

  localparam logic [8:0]        ROWS_L   = 9'(GRID_ROWS);
  localparam logic [8:0]        COLS_L   = 9'(GRID_COLS);
  localparam logic [4:0]        ACTS_L   = 5'(NUM_ACTIONS);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NUM_ACTIONS - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_OLD    = 4'd4;
  localparam logic [3:0] S_MUL1   = 4'd5;
  localparam logic [3:0] S_ERR    = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_WB     = 4'd8;
  localparam logic [3:0] S_RREAD  = 4'd9;
  localparam logic [3:0] S_RWAIT  = 4'd10;
  localparam logic [3:0] S_SDRAIN = 4'd11;
  localparam logic [3:0] S_GRES   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  function automatic logic [ADDR_W-1:0] cell_base(input logic [3:0] r, input logic [3:0] c);
    logic [AX_W-1:0] lin;
    lin = AX_W'(r) * AX_W'(GRID_COLS) + AX_W'(c);
    return ADDR_W'(lin * AX_W'(NUM_ACTIONS));
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  rd_act_r;
  cfg_word_t         lrate_r, disc_r;
  logic              out_valid_r, out_valid_nxt;
  q_t                out_q_r;
  logic [2:0]        out_act_r;

  req_t              req_r;
  logic [3:0]        row_r, col_r, nrow_r, ncol_r;
  logic [2:0]        act_r;
  q_t                reward_r;
  logic [ADDR_W-1:0] cur_base_r, scan_base_r;
  q_t                best_r;
  logic [CNT_W-1:0]  best_act_r;
  q_t                res_q_r;
  logic [2:0]        res_act_r;

  logic              cur_ok, nxt_ok, act_ok;
  logic [ADDR_W-1:0] entry_addr;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  q_t                mem_wdata, mem_rdata;
  q_t                new_val;
  upd_ctl_t          upd_ctl;
  logic              in_acc, out_load;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign cur_ok = ({5'd0, row_r} < ROWS_L) && ({5'd0, col_r} < COLS_L);
  assign nxt_ok = ({5'd0, nrow_r} < ROWS_L) && ({5'd0, ncol_r} < COLS_L);
  assign act_ok = ({2'd0, act_r} < ACTS_L);
  assign entry_addr = cur_base_r + ADDR_W'(act_r);

  assign upd_ctl.mul1 = (state_r == S_MUL1);
  assign upd_ctl.err  = (state_r == S_ERR);
  assign upd_ctl.mul2 = (state_r == S_MUL2);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cnt_nxt   = '0;
        state_nxt = S_DONE;
        unique case (req_r)
          REQ_UPDATE: if (cur_ok && act_ok && nxt_ok) state_nxt = S_SCAN;
          REQ_READ:   if (cur_ok && act_ok) state_nxt = S_RREAD;
          REQ_GREEDY: if (cur_ok) state_nxt = S_SCAN;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = (req_r == REQ_UPDATE) ? S_OLD : S_SDRAIN;
        end
      end
      S_OLD:    state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_ERR;
      S_ERR:    state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_WB;
      S_WB:     state_nxt = S_DONE;
      S_RREAD:  state_nxt = S_RWAIT;
      S_RWAIT:  state_nxt = S_DONE;
      S_SDRAIN: state_nxt = S_GRES;
      S_GRES:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_addr;
    mem_wdata = new_val;
    mem_re    = 1'b0;
    mem_raddr = entry_addr;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_WB) begin
      mem_we = 1'b1;
    end
    if (state_r == S_SCAN) begin
      mem_re    = 1'b1;
      mem_raddr = scan_base_r + ADDR_W'(cnt_r);
    end else if (state_r == S_OLD || state_r == S_RREAD) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lrate_r     <= LRATE_RST;
      disc_r      <= DISC_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LRATE: lrate_r <= cfg_data;
          CFG_DISC:  disc_r  <= cfg_data;
          default:   lrate_r <= lrate_r;
        endcase
      end
    end
  end

  // request fields, scan tracking and result staging
  always_ff @(posedge clk) begin
    rd_act_r <= cnt_r;
    if (in_acc) begin
      req_r    <= in_req_type;
      row_r    <= in_state_row;
      col_r    <= in_state_col;
      act_r    <= in_action_index;
      nrow_r   <= in_next_row;
      ncol_r   <= in_next_col;
      reward_r <= in_reward_value;
    end
    if (state_r == S_START) begin
      cur_base_r  <= cell_base(row_r, col_r);
      scan_base_r <= (req_r == REQ_UPDATE) ? cell_base(nrow_r, ncol_r)
                                           : cell_base(row_r, col_r);
      res_q_r     <= '0;
      res_act_r   <= '0;
    end
    // first action with the largest value wins
    if (rd_vld_r) begin
      if (rd_act_r == '0 || mem_rdata > best_r) begin
        best_r     <= mem_rdata;
        best_act_r <= rd_act_r;
      end
    end
    if (state_r == S_RWAIT) begin
      res_q_r <= mem_rdata;
    end
    if (state_r == S_GRES) begin
      res_q_r   <= best_r;
      res_act_r <= 3'(best_act_r);
    end
    if (state_r == S_WB) begin
      res_q_r <= new_val;
    end
    if (out_load) begin
      out_q_r   <= res_q_r;
      out_act_r <= res_act_r;
    end
  end

  qlu_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qlu_update u_update (
    .clk           (clk),
    .ctl           (upd_ctl),
    .learning_rate (lrate_r),
    .discount      (disc_r),
    .reward        (reward_r),
    .best_next     (best_r),
    .old_val       (mem_rdata),
    .new_val       (new_val)
  );

  assign out_valid       = out_valid_r;
  assign out_q_value     = out_q_r;
  assign out_best_action = out_act_r;

endmodule

`default_nettype wire

[hdl/qlu_table.sv]
// ---------------------------------------------------------------------------
// qlu_table
// value table, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module qlu_table #(
  parameter int DEPTH  = 1280,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire qlu_pkg::q_t       wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output qlu_pkg::q_t            rdata
);
  import qlu_pkg::*;

  q_t mem [DEPTH];
  q_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/qlu_update.sv]
// ---------------------------------------------------------------------------
// qlu_update
// temporal difference arithmetic: discount multiply, error rounding,
// rate multiply, rounding and saturating add
// ---------------------------------------------------------------------------
`default_nettype none

module qlu_update (
  input  wire logic              clk,
  input  wire qlu_pkg::upd_ctl_t ctl,
  input  wire qlu_pkg::cfg_word_t learning_rate,
  input  wire qlu_pkg::cfg_word_t discount,
  input  wire qlu_pkg::q_t       reward,
  input  wire qlu_pkg::q_t       best_next,
  input  wire qlu_pkg::q_t       old_val,
  output qlu_pkg::q_t            new_val
);
  import qlu_pkg::*;

  localparam int P1_W = 49;
  localparam int T_W  = 51;
  localparam int E_W  = 35;
  localparam int P2_W = 52;
  localparam int D_W  = 36;
  localparam int NV_W = 37;

  q_t                     old_r;
  logic signed [P1_W-1:0] prod1_r;
  logic signed [E_W-1:0]  err_r;
  logic signed [P2_W-1:0] prod2_r;

  logic signed [P1_W-1:0] disc_x;
  logic signed [P1_W-1:0] best_x;
  logic signed [T_W-1:0]  rew_x;
  logic signed [T_W-1:0]  old_x;
  logic signed [T_W-1:0]  t_sum;
  logic signed [T_W-1:0]  t_rnd;
  logic signed [P2_W-1:0] lr_x;
  logic signed [P2_W-1:0] err_x;
  logic signed [P2_W-1:0] p2_rnd;
  logic signed [D_W-1:0]  delta;
  logic signed [NV_W-1:0] nv;
  logic [NV_W-32:0]       nv_hi;

  always_comb begin
    disc_x = P1_W'($signed({1'b0, discount}));
    best_x = P1_W'(best_next);
    rew_x  = {{(T_W-48){reward[Q_W-1]}}, reward, 16'd0};
    old_x  = {{(T_W-48){old_r[Q_W-1]}}, old_r, 16'd0};
    t_sum  = rew_x + T_W'(prod1_r) - old_x;
    t_rnd  = t_sum + T_W'(32768);
    lr_x   = P2_W'($signed({1'b0, learning_rate}));
    err_x  = P2_W'(err_r);
    p2_rnd = prod2_r + P2_W'(32768);
    delta  = D_W'(p2_rnd >>> 16);
    nv     = NV_W'(old_r) + NV_W'(delta);
    nv_hi  = nv[NV_W-1:31];
  end

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      old_r   <= old_val;
      prod1_r <= disc_x * best_x;
    end
    if (ctl.err) begin
      err_r <= E_W'(t_rnd >>> 16);
    end
    if (ctl.mul2) begin
      prod2_r <= lr_x * err_x;
    end
  end

  // saturate to the signed 32-bit range
  always_comb begin
    if ((&nv_hi) || !(|nv_hi)) begin
      new_val = nv[Q_W-1:0];
    end else if (nv[NV_W-1]) begin
      new_val = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      new_val = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[hdl/qlu_checker.sv]
// ---------------------------------------------------------------------------
// qlu_checker
// port-level checks of the q-learning update engine, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module qlu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire qlu_pkg::q_t out_q_value,
  input wire logic [2:0]  out_best_action
);
  import qlu_pkg::*;

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_q_value) && $stable(out_best_action))

  // one request in flight
  `ASSERT_CLK(a_one_inflight, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // no result in the cycle right after a request
  `ASSERT_CLK(a_no_instant_result, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid))

  // table clear keeps requests out after reset
  `ASSERT_CLK_ALWAYS(a_clear_after_reset, clk, !rst_n |=> !in_ready)

endmodule

bind tabular_q_learning_update qlu_checker u_qlu_checker (.*);

`default_nettype wire
